// ===== sv/mtfw_pkg.sv =====
// -----------------------------------------------------------------------------
// mtfw_pkg
// Shared types and request codes for the move-to-front window list.
// -----------------------------------------------------------------------------
package mtfw_pkg;

   // request kinds
   localparam logic [1:0] OP_OPEN   = 2'd0;
   localparam logic [1:0] OP_SWITCH = 2'd1;
   localparam logic [1:0] OP_CLOSE  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // fixed field widths of the request and result items
   localparam int unsigned OP_W  = 2;
   localparam int unsigned WID_W = 16;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [WID_W-1:0] window_id;
   } req_type;

   typedef struct packed {
      logic [WID_W-1:0] front_id;
      logic             list_empty;
      logic             full_drop;
   } rsp_type;

endpackage

// ===== sv/move_to_front_window_list.sv =====
// -----------------------------------------------------------------------------
// move_to_front_window_list
// Ordered list of window ids, most recent at the front, kept in one memory
// and maintained by a small sequencer over a shared step/compare unit.
// -----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_item          taken when start && !busy
//  result    rsp_strobe, rsp_item           valid for one cycle, no stall
//
//  An open shifts every entry up and writes the id at the front (a full list
//  drops it); a switch moves a found id to the front; a close removes a found
//  id and shifts the entries behind it down. The single read port of the
//  entry memory sets the pace: search and shift go one position per cycle.
//  Reset clears the sequencer and the entry count; the memory keeps stale
//  contents that are never read below the count. busy is high from the
//  accepted item through the cycle of its result strobe.
// -----------------------------------------------------------------------------
module move_to_front_window_list #(
   parameter int unsigned DEPTH   = 16,
   parameter int unsigned ID_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mtfw_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mtfw_pkg::rsp_type rsp_item
);
   import mtfw_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_LOAD     = 3'd2;
   localparam logic [2:0] ST_SHIFT_UP = 3'd3;
   localparam logic [2:0] ST_SHIFT_DN = 3'd4;
   localparam logic [2:0] ST_HEAD     = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      src_ff, src_in;
   logic [AW-1:0]      dst_ff, dst_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [ID_BITS-1:0] front_ff, front_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic               drop_ff, drop_in;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ID_BITS-1:0] rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ID_BITS-1:0] wr_data;

   logic [CW-1:0]      step_opnd;
   logic               step_down;
   logic [CW-1:0]      step_nxt;
   logic               step_match;
   logic               step_last;

   mtfw_store #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mtfw_step_unit #(
      .ID_BITS (ID_BITS),
      .CW      (CW)
   ) u_step (
      .opnd     (step_opnd),
      .down     (step_down),
      .entry_id (rd_data),
      .key_id   (id_ff),
      .nxt      (step_nxt),
      .match    (step_match)
   );

   // pick the operand and direction of the shared step
   always_comb begin
      step_opnd = CW'(src_ff);
      step_down = 1'b1;
      unique case (state_ff)
         ST_IDLE:     step_opnd = count_ff;
         ST_SCAN,
         ST_SHIFT_DN: step_down = 1'b0;
         default:     step_down = 1'b1;
      endcase
   end

   assign step_last = (step_nxt == count_ff);

   // sequence one item: search, shift, write head, report
   always_comb begin
      state_in = state_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      count_in = count_ff;
      front_in = front_ff;
      id_in    = id_ff;
      op_in    = op_ff;
      drop_in  = drop_ff;
      rd_en    = 1'b0;
      rd_addr  = step_nxt[AW-1:0];
      wr_en    = 1'b0;
      wr_addr  = dst_ff;
      wr_data  = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_item.op;
               id_in   = ID_BITS'(req_item.window_id);
               drop_in = 1'b0;
               unique case (req_item.op)
                  OP_OPEN: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        drop_in  = 1'b1;
                        state_in = ST_DONE;
                     end else if (count_ff == '0) begin
                        state_in = ST_HEAD;
                     end else begin
                        rd_en    = 1'b1;
                        src_in   = step_nxt[AW-1:0];
                        dst_in   = count_ff[AW-1:0];
                        state_in = ST_SHIFT_UP;
                     end
                  end
                  OP_SWITCH,
                  OP_CLOSE: begin
                     if (count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        src_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_SCAN: begin
            if (step_match) begin
               if (op_ff == OP_SWITCH) begin
                  state_in = (src_ff == '0) ? ST_DONE : ST_LOAD;
               end else if (step_last) begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  dst_in   = src_ff;
                  src_in   = step_nxt[AW-1:0];
                  state_in = ST_SHIFT_DN;
               end
            end else if (step_last) begin
               state_in = ST_DONE;
            end else begin
               rd_en  = 1'b1;
               src_in = step_nxt[AW-1:0];
            end
         end

         ST_LOAD: begin
            rd_en    = 1'b1;
            dst_in   = src_ff;
            src_in   = step_nxt[AW-1:0];
            state_in = ST_SHIFT_UP;
         end

         ST_SHIFT_UP: begin
            wr_en = 1'b1;
            if (src_ff == '0) begin
               state_in = ST_HEAD;
            end else begin
               rd_en  = 1'b1;
               dst_in = src_ff;
               src_in = step_nxt[AW-1:0];
            end
         end

         ST_SHIFT_DN: begin
            wr_en = 1'b1;
            if (dst_ff == '0) begin
               front_in = rd_data;
            end
            if (step_last) begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end else begin
               rd_en  = 1'b1;
               dst_in = src_ff;
               src_in = step_nxt[AW-1:0];
            end
         end

         ST_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = id_ff;
            front_in = id_ff;
            if (op_ff == OP_OPEN) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_DONE;
         end

         ST_DONE: state_in = ST_IDLE;

         default: state_in = ST_IDLE;
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   // hold pointers and item payload
   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      front_ff <= front_in;
      id_ff    <= id_in;
      op_ff    <= op_in;
   end

   // drive the result item
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = (state_ff == ST_DONE);
   assign rsp_item.list_empty = (count_ff == '0);
   assign rsp_item.front_id   = (count_ff == '0) ? '0 : WID_W'(front_ff);
   assign rsp_item.full_drop  = drop_ff;

endmodule

// ===== sv/mtfw_store.sv =====
// -----------------------------------------------------------------------------
// mtfw_store
// Entry memory: one write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module mtfw_store #(
   parameter int unsigned DEPTH   = 16,
   parameter int unsigned ID_BITS = 16,
   parameter int unsigned AW      = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ID_BITS-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [ID_BITS-1:0] rd_data
);

   logic [ID_BITS-1:0] mem [DEPTH];
   logic [ID_BITS-1:0] rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one entry, data next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mtfw_step_unit.sv =====
// -----------------------------------------------------------------------------
// mtfw_step_unit
// Shared step unit: one position increment or decrement and one id compare,
// reused by every step of the sequencer.
// -----------------------------------------------------------------------------
module mtfw_step_unit #(
   parameter int unsigned ID_BITS = 16,
   parameter int unsigned CW      = 5
) (
   input  logic [CW-1:0]      opnd,
   input  logic               down,
   input  logic [ID_BITS-1:0] entry_id,
   input  logic [ID_BITS-1:0] key_id,
   output logic [CW-1:0]      nxt,
   output logic               match
);

   // step the position by one
   assign nxt   = down ? (opnd - CW'(1)) : (opnd + CW'(1));

   // compare the entry just read against the request id
   assign match = (entry_id == key_id);

endmodule

// ===== sv/mtfw_checker.sv =====
// -----------------------------------------------------------------------------
// mtfw_checker
// Port-level checks of the move-to-front window list, bound to the top level.
// -----------------------------------------------------------------------------
module mtfw_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mtfw_pkg::req_type req_item,
   input logic              rsp_strobe,
   input mtfw_pkg::rsp_type rsp_item
);
   import mtfw_pkg::*;

   // accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted item");

   // a result comes only while an item is in work
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // one strobe per item, never in back-to-back cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe repeated or block still busy");

   // empty list reports front id zero
   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.list_empty) |-> (rsp_item.front_id == '0))
      else $error("empty list with nonzero front id");

   // req_item is part of the port view
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown(req_item.op))
      else $error("request op unknown at accept");

endmodule

bind move_to_front_window_list mtfw_checker u_mtfw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
